/* hdl/eci_pkg.sv */
`default_nettype none

package eci_pkg;

   // Default widths of the fixed-point fraction and the position.
   localparam int FRAC_BITS_DEF = 16;
   localparam int POS_BITS_DEF  = 12;

   // Register reset values, truncated to the position width where used.
   localparam int START_RESET = 20;
   localparam int END_RESET   = 900;

   // Register indexes on the APB port.
   localparam logic REG_START = 1'b0;
   localparam logic REG_END   = 1'b1;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [2:0] {
      CMD_LINEAR       = 3'd0,
      CMD_IN_QUAD      = 3'd1,
      CMD_OUT_QUAD     = 3'd2,
      CMD_IN_OUT_QUAD  = 3'd3,
      CMD_IN_CUBIC     = 3'd4,
      CMD_OUT_CUBIC    = 3'd5,
      CMD_IN_OUT_CUBIC = 3'd6,
      CMD_OUT_BOUNCE   = 3'd7
   } cmd_type;

endpackage

`default_nettype wire

/* hdl/eci_req_if.sv */
`default_nettype none

interface eci_req_if
   import eci_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   cmd_type              command;
   logic [FRAC_BITS:0]   phase;

   modport source (output valid, command, phase, input ready);
   modport sink (input valid, command, phase, output ready);
endinterface

`default_nettype wire

/* hdl/eci_rsp_if.sv */
`default_nettype none

interface eci_rsp_if
   import eci_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [FRAC_BITS:0]    eased;
   logic [POS_BITS-1:0]   position;

   modport source (output valid, eased, position, input ready);
   modport sink (input valid, eased, position, output ready);
endinterface

`default_nettype wire

/* hdl/easing_curve_interpolator.sv */
// Easing curve interpolator.
// The request channel carries a curve command and a progress phase in
// unsigned Q1.FRAC_BITS; phases above one are taken as one. The response
// channel returns the eased progress, rounded and clamped to [0, 1], and the
// position interpolated between the start and end registers.
// Both channels use a valid/ready handshake; a word moves when both are high.
// The start and end positions are written over the APB port at byte
// addresses 0 and 4 and should only change while no word is in flight.
// A new request is taken every cycle unless the receiver holds the output
// word. The pipeline stages are set by the three multipliers (the square,
// the cubic product and the position product), each with a register before
// and after it. Reset empties the pipeline and loads the start and end
// positions with 20 and 900. When the receiver holds ready low with a
// response pending, the whole pipeline freezes and request ready drops in
// the same cycle; nothing is lost or duplicated.
`default_nettype none

module easing_curve_interpolator
   import eci_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   eci_req_if.sink                        req_chan,
   eci_rsp_if.source                      rsp_chan,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [CSR_DATA_BITS-1:0]  pwdata,
   output logic      [CSR_DATA_BITS-1:0]  prdata,
   output logic                           pready
);

   localparam int W1  = FRAC_BITS + 1;
   localparam int OPW = FRAC_BITS + 2;
   localparam int PW  = 2 * OPW;
   localparam int RW  = PW + 2;
   localparam int SW  = FRAC_BITS + 6;
   localparam int MW  = 2 * W1 + 1;
   localparam int QW  = POS_BITS + FRAC_BITS + 3;

   localparam logic [W1-1:0] ONE_T  = W1'(1) << FRAC_BITS;
   localparam logic [W1-1:0] HALF_T = W1'(1) << (FRAC_BITS - 1);

   localparam logic [SW-1:0] S4  = SW'(4) << FRAC_BITS;
   localparam logic [SW-1:0] S6  = SW'(6) << FRAC_BITS;
   localparam logic [SW-1:0] S8  = SW'(8) << FRAC_BITS;
   localparam logic [SW-1:0] S9  = SW'(9) << FRAC_BITS;
   localparam logic [SW-1:0] S10 = SW'(10) << FRAC_BITS;
   localparam logic [SW-1:0] S21 = SW'(21) << FRAC_BITS;

   localparam logic [W1:0] B_FIRST  = (W1 + 1)'(3) << (FRAC_BITS - 2);
   localparam logic [W1:0] B_SECOND = (W1 + 1)'(15) << (FRAC_BITS - 4);
   localparam logic [W1:0] B_THIRD  = (W1 + 1)'(63) << (FRAC_BITS - 6);

   typedef enum logic [1:0] {
      PIECE_RISE,
      PIECE_FIRST,
      PIECE_SECOND,
      PIECE_THIRD
   } piece_type;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic [POS_BITS-1:0] start_ff;
   logic [POS_BITS-1:0] end_ff;
   logic                csr_wr;
   logic                csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= POS_BITS'(START_RESET);
         end_ff   <= POS_BITS'(END_RESET);
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_START: start_ff <= pwdata[POS_BITS-1:0];
            REG_END:   end_ff   <= pwdata[POS_BITS-1:0];
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_START: prdata = CSR_DATA_BITS'(start_ff);
         REG_END:   prdata = CSR_DATA_BITS'(end_ff);
         default:   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control: every stage moves together unless the output word
   // is held by the receiver.
   // ---------------------------------------------------------------------
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, vo_ff;

   assign adv            = !vo_ff || rsp_chan.ready;
   assign req_chan.ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         vo_ff <= v7_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: input register, phase saturated to one.
   // ---------------------------------------------------------------------
   cmd_type         cmd1_ff;
   logic [W1-1:0]   t1_ff;
   logic [W1-1:0]   t1_in;

   assign t1_in = (req_chan.phase > ONE_T) ? ONE_T : req_chan.phase;

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= req_chan.command;
         t1_ff   <= t1_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 -> 2: pick the value to be squared and the cubic factor.
   // Every curve squares one operand; out-bounce works on s = 11 t split
   // into four parabolic pieces.
   // ---------------------------------------------------------------------
   logic [W1-1:0]  u1;
   logic           lo1;
   logic [SW-1:0]  s_ext;
   logic [SW-1:0]  s11;
   logic [SW-1:0]  s22;
   logic [SW-1:0]  d_bounce;
   piece_type      pc2_in;
   logic [OPW-1:0] op2_in;
   logic [W1-1:0]  y2_in;

   assign u1    = ONE_T - t1_ff;
   assign lo1   = t1_ff < HALF_T;
   assign s_ext = SW'(t1_ff);
   assign s11   = (s_ext << 3) + (s_ext << 1) + s_ext;
   assign s22   = s11 << 1;

   always_comb begin
      if (s11 < S4) begin
         pc2_in   = PIECE_RISE;
         d_bounce = s11;
      end else if (s11 < S8) begin
         pc2_in   = PIECE_FIRST;
         d_bounce = (s11 >= S6) ? s11 - S6 : S6 - s11;
      end else if (s11 < S10) begin
         pc2_in   = PIECE_SECOND;
         d_bounce = (s11 >= S9) ? s11 - S9 : S9 - s11;
      end else begin
         pc2_in   = PIECE_THIRD;
         d_bounce = (s22 >= S21) ? s22 - S21 : S21 - s22;
      end
   end

   always_comb begin
      unique case (cmd1_ff)
         CMD_LINEAR:       op2_in = OPW'(t1_ff);
         CMD_IN_QUAD:      op2_in = OPW'(t1_ff);
         CMD_OUT_QUAD:     op2_in = OPW'(u1);
         CMD_IN_OUT_QUAD:  op2_in = lo1 ? OPW'(t1_ff) : OPW'(u1);
         CMD_IN_CUBIC:     op2_in = OPW'(t1_ff);
         CMD_OUT_CUBIC:    op2_in = OPW'(u1);
         CMD_IN_OUT_CUBIC: op2_in = lo1 ? (OPW'(t1_ff) << 1) : (OPW'(u1) << 1);
         CMD_OUT_BOUNCE:   op2_in = d_bounce[OPW-1:0];
         default:          op2_in = '0;
      endcase
   end

   always_comb begin
      unique case (cmd1_ff)
         CMD_OUT_CUBIC:    y2_in = u1;
         CMD_IN_OUT_CUBIC: y2_in = lo1 ? t1_ff : u1;
         default:          y2_in = t1_ff;
      endcase
   end

   cmd_type        cmd2_ff;
   logic [W1-1:0]  t2_ff;
   logic           lo2_ff;
   piece_type      pc2_ff;
   logic [OPW-1:0] op2_ff;
   logic [W1-1:0]  y2_2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd2_ff <= cmd1_ff;
         t2_ff   <= t1_ff;
         lo2_ff  <= lo1;
         pc2_ff  <= pc2_in;
         op2_ff  <= op2_in;
         y2_2_ff <= y2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2 -> 3: the square.
   // ---------------------------------------------------------------------
   cmd_type        cmd3_ff;
   logic [W1-1:0]  t3_ff;
   logic           lo3_ff;
   piece_type      pc3_ff;
   logic [W1-1:0]  y2_3_ff;
   logic [PW-1:0]  prod3_ff;
   logic [PW-1:0]  prod3_in;

   assign prod3_in = op2_ff * op2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd3_ff  <= cmd2_ff;
         t3_ff    <= t2_ff;
         lo3_ff   <= lo2_ff;
         pc3_ff   <= pc2_ff;
         y2_3_ff  <= y2_2_ff;
         prod3_ff <= prod3_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3 -> 4: round the square back to Q1.F. In-out-quad doubles it
   // first; out-bounce divides by 16 (or 64 on its last piece) as well.
   // ---------------------------------------------------------------------
   logic [RW-1:0] sq_base;
   logic [RW-1:0] sq_sum;
   logic [W1-1:0] r4_in;

   always_comb begin
      sq_base = (cmd3_ff == CMD_IN_OUT_QUAD) ? (RW'(prod3_ff) << 1) : RW'(prod3_ff);
      if (cmd3_ff == CMD_OUT_BOUNCE && pc3_ff == PIECE_THIRD) begin
         sq_sum = sq_base + (RW'(1) << (FRAC_BITS + 5));
         r4_in  = W1'(sq_sum >> (FRAC_BITS + 6));
      end else if (cmd3_ff == CMD_OUT_BOUNCE) begin
         sq_sum = sq_base + (RW'(1) << (FRAC_BITS + 3));
         r4_in  = W1'(sq_sum >> (FRAC_BITS + 4));
      end else begin
         sq_sum = sq_base + RW'(HALF_T);
         r4_in  = W1'(sq_sum >> FRAC_BITS);
      end
   end

   cmd_type        cmd4_ff;
   logic [W1-1:0]  t4_ff;
   logic           lo4_ff;
   piece_type      pc4_ff;
   logic [W1-1:0]  y2_4_ff;
   logic [W1-1:0]  r4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd4_ff <= cmd3_ff;
         t4_ff   <= t3_ff;
         lo4_ff  <= lo3_ff;
         pc4_ff  <= pc3_ff;
         y2_4_ff <= y2_3_ff;
         r4_ff   <= r4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4 -> 5: the cubic product.
   // ---------------------------------------------------------------------
   cmd_type          cmd5_ff;
   logic [W1-1:0]    t5_ff;
   logic             lo5_ff;
   piece_type        pc5_ff;
   logic [W1-1:0]    r5_ff;
   logic [2*W1-1:0]  prod5_ff;
   logic [2*W1-1:0]  prod5_in;

   assign prod5_in = r4_ff * y2_4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd5_ff  <= cmd4_ff;
         t5_ff    <= t4_ff;
         lo5_ff   <= lo4_ff;
         pc5_ff   <= pc4_ff;
         r5_ff    <= r4_ff;
         prod5_ff <= prod5_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5 -> 6: finish the curve and clamp to one.
   // ---------------------------------------------------------------------
   logic [MW-1:0] m2_sum;
   logic [W1-1:0] m2;
   logic [W1:0]   b_off;
   logic [W1:0]   e_wide;
   logic [W1-1:0] e6_in;

   assign m2_sum = MW'(prod5_ff) + MW'(HALF_T);
   assign m2     = W1'(m2_sum >> FRAC_BITS);

   always_comb begin
      unique case (pc5_ff)
         PIECE_RISE:   b_off = '0;
         PIECE_FIRST:  b_off = B_FIRST;
         PIECE_SECOND: b_off = B_SECOND;
         PIECE_THIRD:  b_off = B_THIRD;
         default:      b_off = '0;
      endcase
   end

   always_comb begin
      unique case (cmd5_ff)
         CMD_LINEAR:       e_wide = (W1 + 1)'(t5_ff);
         CMD_IN_QUAD:      e_wide = (W1 + 1)'(r5_ff);
         CMD_OUT_QUAD:     e_wide = (W1 + 1)'(ONE_T - r5_ff);
         CMD_IN_OUT_QUAD:  e_wide = lo5_ff ? (W1 + 1)'(r5_ff) : (W1 + 1)'(ONE_T - r5_ff);
         CMD_IN_CUBIC:     e_wide = (W1 + 1)'(m2);
         CMD_OUT_CUBIC:    e_wide = (W1 + 1)'(ONE_T - m2);
         CMD_IN_OUT_CUBIC: e_wide = lo5_ff ? (W1 + 1)'(m2) : (W1 + 1)'(ONE_T - m2);
         CMD_OUT_BOUNCE:   e_wide = (W1 + 1)'(r5_ff) + b_off;
         default:          e_wide = '0;
      endcase
      e6_in = (e_wide > (W1 + 1)'(ONE_T)) ? ONE_T : e_wide[W1-1:0];
   end

   logic [W1-1:0] e6_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e6_ff <= e6_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6 -> 7: position product (end - start)*e; start*ONE is added next.
   // ---------------------------------------------------------------------
   logic signed [POS_BITS:0] delta;
   logic signed [W1:0]       e_s;
   logic signed [QW-1:0]     q7_in;
   logic signed [QW-1:0]     q7_ff;
   logic [W1-1:0]            e7_ff;

   assign delta = signed'({1'b0, end_ff}) - signed'({1'b0, start_ff});
   assign e_s   = signed'({1'b0, e6_ff});
   assign q7_in = delta * e_s;

   always_ff @(posedge clock) begin
      if (adv) begin
         e7_ff <= e6_ff;
         q7_ff <= q7_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7 -> output: round the position.
   // ---------------------------------------------------------------------
   logic signed [QW-1:0]  pos_sum;
   logic [POS_BITS-1:0]   pos_in;
   logic [W1-1:0]         eased_ff;
   logic [POS_BITS-1:0]   position_ff;

   assign pos_sum = signed'(QW'(start_ff) << FRAC_BITS) + q7_ff + signed'(QW'(HALF_T));
   assign pos_in  = pos_sum[FRAC_BITS+POS_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         eased_ff    <= e7_ff;
         position_ff <= pos_in;
      end
   end

   assign rsp_chan.valid    = vo_ff;
   assign rsp_chan.eased    = eased_ff;
   assign rsp_chan.position = position_ff;

`ifndef ASSERT_OFF
   a_eased_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.eased <= ONE_T))
      else $error("eased value above one");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the response word is stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

/* tb/tb_easing_curve_interpolator.sv */
`timescale 1ns / 1ps

import eci_pkg::*;

// Holds the eased value and position expected for every request word still in
// flight, worked out from its own copy of the start and end positions.
class ease_scoreboard;
   localparam int FB = FRAC_BITS_DEF;
   localparam logic [63:0] ONE  = 64'd1 << FB;
   localparam logic [63:0] HALF = ONE >> 1;

   logic [FB:0]             eased_q[$];
   logic [POS_BITS_DEF-1:0] position_q[$];
   logic [POS_BITS_DEF-1:0] start_pos;
   logic [POS_BITS_DEF-1:0] end_pos;
   int errors;
   int requests;
   int checked;

   function new();
      start_pos = POS_BITS_DEF'(START_RESET);
      end_pos = POS_BITS_DEF'(END_RESET);
      errors = 0;
      requests = 0;
      checked = 0;
   endfunction

   function logic [63:0] round_mul(logic [63:0] a, logic [63:0] b);
      return (a * b + HALF) >> FB;
   endfunction

   function logic [63:0] square_scaled(logic [63:0] d, int extra);
      return (d * d + (64'd1 << (FB + extra - 1))) >> (FB + extra);
   endfunction

   function logic [63:0] distance(logic [63:0] a, logic [63:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // The 7.5625 factor of the bounce is folded in as 121/16 by scaling t by 11.
   function logic [63:0] bounce_curve(logic [63:0] t);
      logic [63:0] s;
      s = 64'd11 * t;
      if (s < 4 * ONE)
         return square_scaled(s, 4);
      if (s < 8 * ONE)
         return square_scaled(distance(s, 6 * ONE), 4) + (3 * ONE) / 4;
      if (s < 10 * ONE)
         return square_scaled(distance(s, 9 * ONE), 4) + (15 * ONE) / 16;
      return square_scaled(distance(2 * s, 21 * ONE), 6) + (63 * ONE) / 64;
   endfunction

   function logic [63:0] eased_value(cmd_type cmd, logic [63:0] t);
      logic [63:0] u;
      u = ONE - t;
      case (cmd)
         CMD_LINEAR:      return t;
         CMD_IN_QUAD:     return round_mul(t, t);
         CMD_OUT_QUAD:    return ONE - round_mul(u, u);
         CMD_IN_OUT_QUAD: begin
            if (t < HALF)
               return (2 * t * t + HALF) >> FB;
            return ONE - ((2 * u * u + HALF) >> FB);
         end
         CMD_IN_CUBIC:    return round_mul(round_mul(t, t), t);
         CMD_OUT_CUBIC:   return ONE - round_mul(round_mul(u, u), u);
         CMD_IN_OUT_CUBIC: begin
            if (t < HALF)
               return round_mul(round_mul(2 * t, 2 * t), t);
            return ONE - round_mul(round_mul(2 * u, 2 * u), u);
         end
         CMD_OUT_BOUNCE:  return bounce_curve(t);
         default:         return 64'd0;
      endcase
   endfunction

   function void note_request(cmd_type cmd, logic [FB:0] phase);
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] pos;
      t = (64'(phase) > ONE) ? ONE : 64'(phase);
      e = eased_value(cmd, t);
      if (e > ONE)
         e = ONE;
      pos = (64'(start_pos) * (ONE - e) + 64'(end_pos) * e + HALF) >> FB;
      eased_q.push_back(e[FB:0]);
      position_q.push_back(pos[POS_BITS_DEF-1:0]);
      requests++;
   endfunction

   function void check_response(logic [FB:0] eased, logic [POS_BITS_DEF-1:0] position);
      logic [FB:0]             want_eased;
      logic [POS_BITS_DEF-1:0] want_position;
      if (eased_q.size() == 0) begin
         $error("response word with no request outstanding: eased %0d position %0d",
                eased, position);
         errors++;
         return;
      end
      want_eased = eased_q.pop_front();
      want_position = position_q.pop_front();
      checked++;
      if (eased !== want_eased) begin
         $error("eased: expected %0d, got %0d", want_eased, eased);
         errors++;
      end
      if (position !== want_position) begin
         $error("position: expected %0d, got %0d", want_position, position);
         errors++;
      end
   endfunction

   function int pending();
      return eased_q.size();
   endfunction
endclass

module tb_easing_curve_interpolator;
   localparam int FB = FRAC_BITS_DEF;
   localparam int ONE = 1 << FB;
   localparam logic [FB:0] PH_ONE  = (FB + 1)'(ONE);
   localparam logic [FB:0] PH_HALF = (FB + 1)'(ONE / 2);
   localparam logic [CSR_ADDR_BITS-1:0] START_ADDR = {REG_START, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] END_ADDR   = {REG_END, 2'b00};

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // While set, neither side inserts gaps or stalls.
   bit steady;
   int settings_used;

   ease_scoreboard sb;

   eci_req_if req_chan ();
   eci_rsp_if rsp_chan ();

   easing_curve_interpolator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_easing_curve_interpolator failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_response(rsp_chan.eased, rsp_chan.position);
   end

   // Receiver: stalls a random number of cycles before taking each word.
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   task automatic send_word(cmd_type cmd, logic [FB:0] phase);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.command = cmd;
      req_chan.phase = phase;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_request(cmd, phase);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(logic write, logic [CSR_ADDR_BITS-1:0] addr,
                             logic [CSR_DATA_BITS-1:0] data);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = write;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (!write && prdata[POS_BITS_DEF-1:0] !== data[POS_BITS_DEF-1:0]) begin
         $error("register %0d: expected %0d, got %0d", addr, data[POS_BITS_DEF-1:0],
                prdata[POS_BITS_DEF-1:0]);
         sb.errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_positions(int start_value, int end_value);
      wait_idle();
      csr_access(1'b1, START_ADDR, start_value);
      csr_access(1'b1, END_ADDR, end_value);
      sb.start_pos = start_value[POS_BITS_DEF-1:0];
      sb.end_pos = end_value[POS_BITS_DEF-1:0];
      csr_access(1'b0, START_ADDR, start_value);
      csr_access(1'b0, END_ADDR, end_value);
      settings_used++;
   endtask

   // Mostly phases inside [0, 1], with some crowding the ends, the midpoint,
   // the bounce segment joints and the full 17-bit range.
   function automatic logic [FB:0] random_phase();
      int pick;
      int joint;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return (FB + 1)'($urandom_range(0, (2 * ONE) - 1));
         1: return (FB + 1)'($urandom_range(0, 15));
         2: return (FB + 1)'($urandom_range(ONE - 15, ONE + 2));
         3: begin
            case ($urandom_range(0, 3))
               0: joint = 23831;
               1: joint = 47662;
               2: joint = 59578;
               default: joint = ONE / 2;
            endcase
            return (FB + 1)'(joint + $urandom_range(0, 4) - 2);
         end
         default: return (FB + 1)'($urandom_range(0, ONE));
      endcase
   endfunction

   initial begin
      int start_table [7];
      int end_table [7];
      sb = new();
      steady = 1'b0;
      settings_used = 1;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_LINEAR;
      req_chan.phase = '0;
      start_table = '{0, 4095, 0, 4095, 1234, 0, 0};
      end_table = '{4095, 0, 0, 4095, 1233, 0, 0};
      start_table[5] = $urandom_range(0, 4095);
      end_table[5] = $urandom_range(0, 4095);
      start_table[6] = $urandom_range(0, 4095);
      end_table[6] = $urandom_range(0, 4095);
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every curve at both ends of the range, under the reset positions.
      for (int c = 0; c < 8; c++) begin
         send_word(cmd_type'(c), '0);
         send_word(cmd_type'(c), PH_ONE);
      end
      // Both halves of the piecewise curves, phase saturation and the
      // bounce segment joints.
      send_word(CMD_IN_OUT_QUAD, PH_HALF - 1'b1);
      send_word(CMD_IN_OUT_QUAD, PH_HALF);
      send_word(CMD_IN_OUT_CUBIC, PH_HALF - 1'b1);
      send_word(CMD_IN_OUT_CUBIC, PH_HALF);
      send_word(CMD_LINEAR, '1);
      send_word(CMD_OUT_BOUNCE, PH_ONE + 1'b1);
      send_word(CMD_OUT_BOUNCE, (FB + 1)'(23831));
      send_word(CMD_OUT_BOUNCE, (FB + 1)'(47662));
      send_word(CMD_OUT_BOUNCE, (FB + 1)'(59578));

      for (int p = 0; p < 7; p++) begin
         set_positions(start_table[p], end_table[p]);
         steady = (p == 2 || p == 5);
         for (int i = 0; i < 90; i++)
            send_word(cmd_type'($urandom_range(0, 7)), random_phase());
         steady = 1'b0;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d words over all eight curves under %0d start/end settings,",
               sb.requests, settings_used);
      $display("including reversed and equal positions; %0d response words checked.",
               sb.checked);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_easing_curve_interpolator passed");
      else
         $display("tb_easing_curve_interpolator failed");
      $finish;
   end
endmodule

/* filelist.f */
hdl/eci_pkg.sv
hdl/eci_req_if.sv
hdl/eci_rsp_if.sv
hdl/easing_curve_interpolator.sv
tb/tb_easing_curve_interpolator.sv
